### hdl/sqm_pkg.sv
// Shared types and constants for the SPI/SQI master shifter.
// Holds the item kinds, direction codes and the command and response item structs.
// No dependencies.
package sqm_pkg;

	localparam int WORD_BITS = 32;
	localparam int DEVICES   = 3;
	localparam int CNT_W     = $clog2(WORD_BITS + 1);
	localparam int DATA_W    = 32;
	localparam int LINES_W   = 4;
	localparam int SEL_W     = 3;
	localparam int NIB_W     = 4;
	localparam int MOSI_BIT  = 0;
	localparam int MISO_BIT  = 1;
	localparam int HOLD_BIT  = 3;

	localparam logic [LINES_W-1:0] LINES_RESET = 4'b1000;

	typedef enum logic [1:0] {
		KIND_SELECT   = 2'd0,
		KIND_DESELECT = 2'd1,
		KIND_LOAD     = 2'd2,
		KIND_TICK     = 2'd3
	} kind_t;

	localparam logic [1:0] DIR_WRITE = 2'd0;
	localparam logic [1:0] DIR_READ  = 2'd1;
	localparam logic [1:0] DIR_BOTH  = 2'd2;
	localparam logic [1:0] DIR_NONE  = 2'd3;

	typedef struct packed {
		kind_t               kind;
		logic [1:0]          device;
		logic                quad;
		logic [1:0]          direction;
		logic [DATA_W-1:0]   out_word;
		logic [5:0]          bit_count;
		logic [LINES_W-1:0]  lines_in;
	} cmd_t;

	typedef struct packed {
		logic [LINES_W-1:0]  lines_out;
		logic [SEL_W-1:0]    selects_n;
		logic                clock_pulse;
		logic                busy_res;
		logic                done_res;
		logic [DATA_W-1:0]   in_word;
		logic                status;
	} rsp_t;

endpackage

### hdl/spi_quad_master_shifter.sv
// SPI/SQI master shifter: single-line SPI or four-line SQI with active-low selects.
// Command items come in on cmd (valid/ready) and one response item per command
// leaves on rsp (valid/ready), in order.
// Kinds: select and deselect a device, load a transfer of 1 to 32 bits, and
// tick, which issues one serial clock pulse and shifts one bit or one nibble.
// The tick that ends a transfer sets done_res and returns the read word.
// A command is registered in the input register on acceptance, and its response
// is registered in the response register when the update pass fires.
// Throughput: one item per cycle while the receiver takes responses, set by the
// single update pass between the input register and the response register.
// While the receiver stalls, the response register holds and the input register
// holds one more item; cmd_ready drops once both are full.
// Reset empties both registers, deselects all devices, drives the hold line high
// and leaves no transfer pending.
// Depends on sqm_pkg, sqm_in_reg and sqm_core.
module spi_quad_master_shifter (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  sqm_pkg::cmd_t cmd,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output sqm_pkg::rsp_t rsp
);
	import sqm_pkg::*;

	logic advance;
	logic item_valid;
	logic fire;
	cmd_t item;
	rsp_t result;
	logic rsp_valid_q;
	rsp_t rsp_q;

	assign advance   = !rsp_valid_q || rsp_ready;
	assign fire      = item_valid && advance;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	sqm_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd),
		.advance    (advance),
		.item_valid (item_valid),
		.item       (item)
	);

	sqm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (fire),
		.item   (item),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q <= result;
		end
	end

endmodule

### hdl/sqm_in_reg.sv
// Input register stage of the SPI/SQI master shifter.
// Captures one command item per cycle while the stage ahead advances.
// Depends on sqm_pkg.
module sqm_in_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  sqm_pkg::cmd_t cmd,
	input  logic          advance,
	output logic          item_valid,
	output sqm_pkg::cmd_t item
);
	import sqm_pkg::*;

	logic valid_s1;
	cmd_t cmd_s1;

	assign cmd_ready  = !valid_s1 || advance;
	assign item_valid = valid_s1;
	assign item       = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cmd_s1 <= cmd;
		end
	end

endmodule

### hdl/sqm_core.sv
// Transfer state and per-item update logic of the SPI/SQI master shifter.
// Holds the shift registers, bit counter, line drive and chip selects.
// Depends on sqm_pkg.
module sqm_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  sqm_pkg::cmd_t item,
	output sqm_pkg::rsp_t result
);
	import sqm_pkg::*;

	logic [WORD_BITS-1:0] shift_out_q, shift_out_d;
	logic [WORD_BITS-1:0] shift_in_q, shift_in_d;
	logic [CNT_W-1:0]     bits_left_q, bits_left_d;
	logic                 mode_quad_q, mode_quad_d;
	logic [1:0]           xfer_dir_q, xfer_dir_d;
	logic [LINES_W-1:0]   line_drive_q, line_drive_d;
	logic [DEVICES-1:0]   select_q, select_d;

	logic                 dev_ok;
	logic                 bad_load;
	logic                 writes;
	logic                 reads;
	logic [CNT_W-1:0]     quad_shift;
	logic [WORD_BITS-1:0] out_shifted;
	logic                 pulse;
	logic                 done;

	always_comb begin
		shift_out_d  = shift_out_q;
		shift_in_d   = shift_in_q;
		bits_left_d  = bits_left_q;
		mode_quad_d  = mode_quad_q;
		xfer_dir_d   = xfer_dir_q;
		line_drive_d = line_drive_q;
		select_d     = select_q;
		pulse        = 1'b0;
		done         = 1'b0;
		dev_ok       = int'(item.device) < DEVICES;
		writes       = (xfer_dir_q == DIR_WRITE) || (xfer_dir_q == DIR_BOTH);
		reads        = (xfer_dir_q == DIR_READ) || (xfer_dir_q == DIR_BOTH);
		quad_shift   = (bits_left_q >= CNT_W'(NIB_W)) ? bits_left_q - CNT_W'(NIB_W)
			: '0;
		out_shifted  = '0;
		bad_load     = (bits_left_q != '0) || (item.bit_count == '0) ||
			(int'(item.bit_count) > WORD_BITS) || (item.direction == DIR_NONE) ||
			(item.quad && ((item.bit_count[1:0] != 2'd0) || (item.direction == DIR_BOTH)));

		case (item.kind)
			KIND_SELECT: begin
				for (int i = 0; i < DEVICES; i++) begin
					if (int'(item.device) == i) begin
						select_d[i] = 1'b0;
					end
				end
				if (dev_ok && !item.quad && (item.device == 2'd1 || item.device == 2'd2)) begin
					line_drive_d[HOLD_BIT] = 1'b1;
				end
			end
			KIND_DESELECT: begin
				for (int i = 0; i < DEVICES; i++) begin
					if (int'(item.device) == i) begin
						select_d[i] = 1'b1;
					end
				end
			end
			KIND_LOAD: begin
				if (!bad_load) begin
					shift_out_d = WORD_BITS'(item.out_word);
					shift_in_d  = '0;
					bits_left_d = CNT_W'(item.bit_count);
					mode_quad_d = item.quad;
					xfer_dir_d  = item.direction;
				end
			end
			KIND_TICK: begin
				if (bits_left_q != '0) begin
					pulse = 1'b1;
					if (mode_quad_q) begin
						out_shifted = shift_out_q >> quad_shift;
						if (writes) begin
							line_drive_d = out_shifted[NIB_W-1:0];
						end
						if (reads) begin
							shift_in_d = {shift_in_q[WORD_BITS-NIB_W-1:0], item.lines_in};
						end
						bits_left_d = quad_shift;
					end else begin
						out_shifted = shift_out_q >> (bits_left_q - CNT_W'(1));
						if (writes) begin
							line_drive_d[MOSI_BIT] = out_shifted[0];
						end
						if (reads) begin
							shift_in_d = {shift_in_q[WORD_BITS-2:0], item.lines_in[MISO_BIT]};
						end
						bits_left_d = bits_left_q - CNT_W'(1);
					end
					if (bits_left_d == '0) begin
						done = 1'b1;
						if (xfer_dir_q == DIR_WRITE) begin
							if (mode_quad_q) begin
								line_drive_d = '0;
							end else begin
								line_drive_d[MOSI_BIT] = 1'b0;
							end
						end
					end
				end
			end
			default: begin
			end
		endcase

		result.lines_out   = line_drive_d;
		result.selects_n   = SEL_W'(select_d);
		result.clock_pulse = pulse;
		result.busy_res    = bits_left_d != '0;
		result.done_res    = done;
		result.in_word     = done ? DATA_W'(shift_in_d) : '0;
		result.status      = (item.kind == KIND_LOAD) && bad_load;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_out_q  <= '0;
			shift_in_q   <= '0;
			bits_left_q  <= '0;
			mode_quad_q  <= 1'b0;
			xfer_dir_q   <= DIR_WRITE;
			line_drive_q <= LINES_RESET;
			select_q     <= '1;
		end else if (step) begin
			shift_out_q  <= shift_out_d;
			shift_in_q   <= shift_in_d;
			bits_left_q  <= bits_left_d;
			mode_quad_q  <= mode_quad_d;
			xfer_dir_q   <= xfer_dir_d;
			line_drive_q <= line_drive_d;
			select_q     <= select_d;
		end
	end

endmodule

### verif/spi_quad_master_shifter_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for spi_quad_master_shifter: directed table, then random transfers.
// Predicts responses from its own bus model or the directed table and compares field by field.
// Depends on sqm_pkg and the spi_quad_master_shifter RTL.
module spi_quad_master_shifter_tb;
	import sqm_pkg::*;

	localparam int TARGET_ITEMS = 550;
	localparam int HOLD_OFF     = 300;
	localparam int IDLE_LIMIT   = 2000;
	localparam int SETTLE       = 10;

	typedef struct packed {
		cmd_t cmd;
		logic typed;
		rsp_t want;
		logic drain;
	} plan_t;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  cmd_valid = 1'b0;
	logic  cmd_ready;
	cmd_t  cmd = '0;
	logic  rsp_valid;
	logic  rsp_ready = 1'b0;
	rsp_t  rsp;

	logic [DATA_W-1:0]  sh_out = '0;
	logic [DATA_W-1:0]  sh_in = '0;
	logic [5:0]         bits_rem = '0;
	logic               quad_mode = 1'b0;
	logic [1:0]         xfer_dir = DIR_WRITE;
	logic [LINES_W-1:0] drive_lines = LINES_RESET;
	logic [SEL_W-1:0]   cs_n = '1;

	plan_t plan_q[$];
	plan_t dir_rows[25];
	rsp_t  pending_rsp[$];
	plan_t typed_now = '0;
	int    mismatches = 0;
	int    idle_cycles = 0;

	spi_quad_master_shifter DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	function automatic rsp_t bus_step(input cmd_t c);
		rsp_t r;
		logic bad;
		logic wr;
		logic rd;
		int   sh;
		r = '0;
		case (c.kind)
			KIND_SELECT: begin
				if (c.device < DEVICES) begin
					cs_n[c.device] = 1'b0;
					if (!c.quad && (c.device == 2'd1 || c.device == 2'd2))
						drive_lines[HOLD_BIT] = 1'b1;
				end
			end
			KIND_DESELECT: begin
				if (c.device < DEVICES)
					cs_n[c.device] = 1'b1;
			end
			KIND_LOAD: begin
				bad = bits_rem != 0 || c.bit_count == 0 || c.bit_count > WORD_BITS ||
					c.direction == DIR_NONE ||
					(c.quad && (c.bit_count[1:0] != 2'd0 || c.direction == DIR_BOTH));
				if (bad) begin
					r.status = 1'b1;
				end else begin
					sh_out    = c.out_word;
					sh_in     = '0;
					bits_rem  = c.bit_count;
					quad_mode = c.quad;
					xfer_dir  = c.direction;
				end
			end
			KIND_TICK: begin
				if (bits_rem != 0) begin
					wr = xfer_dir == DIR_WRITE || xfer_dir == DIR_BOTH;
					rd = xfer_dir == DIR_READ || xfer_dir == DIR_BOTH;
					r.clock_pulse = 1'b1;
					if (quad_mode) begin
						sh = bits_rem >= NIB_W ? bits_rem - NIB_W : 0;
						if (wr)
							drive_lines = sh_out[sh +: NIB_W];
						if (rd)
							sh_in = {sh_in[DATA_W-NIB_W-1:0], c.lines_in};
						bits_rem = bits_rem >= NIB_W ? 6'(bits_rem - NIB_W) : 6'd0;
					end else begin
						if (wr)
							drive_lines[MOSI_BIT] = sh_out[bits_rem - 1];
						if (rd)
							sh_in = {sh_in[DATA_W-2:0], c.lines_in[MISO_BIT]};
						bits_rem = bits_rem - 6'd1;
					end
					if (bits_rem == 0) begin
						r.done_res = 1'b1;
						r.in_word  = sh_in;
						if (xfer_dir == DIR_WRITE) begin
							if (quad_mode)
								drive_lines = '0;
							else
								drive_lines[MOSI_BIT] = 1'b0;
						end
					end
				end
			end
			default: begin
			end
		endcase
		r.lines_out = drive_lines;
		r.selects_n = cs_n;
		r.busy_res  = bits_rem != 0;
		return r;
	endfunction

	function automatic cmd_t mk(kind_t k, int dev, logic q, logic [1:0] d,
			logic [DATA_W-1:0] w, int n, int ln);
		cmd_t c;
		c.kind      = k;
		c.device    = dev[1:0];
		c.quad      = q;
		c.direction = d;
		c.out_word  = w;
		c.bit_count = n[5:0];
		c.lines_in  = ln[3:0];
		return c;
	endfunction

	function automatic rsp_t resp(logic [3:0] ln, logic [2:0] sel, logic pulse, logic busy,
			logic done, logic [DATA_W-1:0] word, logic st);
		rsp_t r;
		r.lines_out   = ln;
		r.selects_n   = sel;
		r.clock_pulse = pulse;
		r.busy_res    = busy;
		r.done_res    = done;
		r.in_word     = word;
		r.status      = st;
		return r;
	endfunction

	function automatic plan_t row(cmd_t c, logic typed, rsp_t want);
		plan_t p;
		p.cmd   = c;
		p.typed = typed;
		p.want  = want;
		p.drain = 1'b0;
		return p;
	endfunction

	task automatic add(cmd_t c, logic drain);
		plan_t p;
		p = row(c, 1'b0, '0);
		p.drain = drain;
		plan_q.push_back(p);
	endtask

	function automatic cmd_t good_load(logic q);
		int n;
		logic [1:0] d;
		d = q ? 2'($urandom_range(0, 1)) : 2'($urandom_range(0, 2));
		if ($urandom_range(0, 9) == 0)
			n = q ? 4 * $urandom_range(1, 8) : $urandom_range(1, 32);
		else
			n = q ? 4 * $urandom_range(1, 2) : $urandom_range(1, 8);
		return mk(KIND_LOAD, 0, q, d, $urandom, n, $urandom_range(0, 15));
	endfunction

	task automatic build_plan();
		cmd_t c;
		int   r;
		int   nt;
		int   k;
		logic drain;
		dir_rows = '{
			row(mk(KIND_TICK, 0, 0, DIR_WRITE, 0, 0, 15), 1, resp(4'h8, 3'h7, 0, 0, 0, 0, 0)),
			row(mk(KIND_DESELECT, 3, 0, DIR_WRITE, 0, 0, 0), 1,
				resp(4'h8, 3'h7, 0, 0, 0, 0, 0)),
			row(mk(KIND_SELECT, 3, 0, DIR_WRITE, 0, 0, 0), 1, resp(4'h8, 3'h7, 0, 0, 0, 0, 0)),
			row(mk(KIND_LOAD, 0, 0, DIR_WRITE, 32'hFFFFFFFF, 0, 0), 1,
				resp(4'h8, 3'h7, 0, 0, 0, 0, 1)),
			row(mk(KIND_LOAD, 0, 0, DIR_WRITE, 0, 33, 0), 1, resp(4'h8, 3'h7, 0, 0, 0, 0, 1)),
			row(mk(KIND_LOAD, 0, 0, DIR_READ, 0, 63, 0), 1, resp(4'h8, 3'h7, 0, 0, 0, 0, 1)),
			row(mk(KIND_LOAD, 0, 0, DIR_NONE, 0, 8, 0), 1, resp(4'h8, 3'h7, 0, 0, 0, 0, 1)),
			row(mk(KIND_LOAD, 0, 1, DIR_READ, 0, 6, 0), 1, resp(4'h8, 3'h7, 0, 0, 0, 0, 1)),
			row(mk(KIND_LOAD, 0, 1, DIR_BOTH, 0, 8, 0), 1, resp(4'h8, 3'h7, 0, 0, 0, 0, 1)),
			row(mk(KIND_SELECT, 0, 1, DIR_WRITE, 0, 0, 0), 0, '0),
			row(mk(KIND_LOAD, 0, 1, DIR_WRITE, 32'hFFFFFFFF, 4, 0), 0, '0),
			row(mk(KIND_TICK, 0, 0, DIR_WRITE, 0, 0, 0), 0, '0),
			row(mk(KIND_LOAD, 0, 0, DIR_BOTH, 32'h2, 2, 0), 0, '0),
			row(mk(KIND_LOAD, 0, 0, DIR_WRITE, 0, 32, 0), 0, '0),
			row(mk(KIND_TICK, 0, 0, DIR_WRITE, 0, 0, 2), 0, '0),
			row(mk(KIND_TICK, 0, 0, DIR_WRITE, 0, 0, 13), 0, '0),
			row(mk(KIND_SELECT, 1, 1, DIR_WRITE, 0, 0, 0), 0, '0),
			row(mk(KIND_SELECT, 2, 0, DIR_WRITE, 0, 0, 0), 0, '0),
			row(mk(KIND_LOAD, 0, 1, DIR_READ, 0, 4, 0), 0, '0),
			row(mk(KIND_TICK, 0, 0, DIR_WRITE, 0, 0, 10), 0, '0),
			row(mk(KIND_LOAD, 0, 0, DIR_WRITE, 32'h1, 1, 0), 0, '0),
			row(mk(KIND_TICK, 0, 0, DIR_WRITE, 0, 0, 0), 0, '0),
			row(mk(KIND_DESELECT, 0, 0, DIR_WRITE, 0, 0, 0), 0, '0),
			row(mk(KIND_DESELECT, 1, 0, DIR_WRITE, 0, 0, 0), 0, '0),
			row(mk(KIND_DESELECT, 2, 0, DIR_WRITE, 0, 0, 0), 0, '0)
		};
		foreach (dir_rows[i])
			plan_q.push_back(dir_rows[i]);

		drain = 1'b1;
		while (plan_q.size() < TARGET_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 10) begin
				c = mk(kind_t'($urandom_range(0, 3)), $urandom_range(0, 3),
					1'($urandom_range(0, 1)),
					2'($urandom_range(0, 3)), $urandom, $urandom_range(0, 63),
					$urandom_range(0, 15));
				add(c, drain);
			end else begin
				if ($urandom_range(0, 2) == 0)
					add(mk($urandom_range(0, 3) == 0 ? KIND_DESELECT : KIND_SELECT,
						$urandom_range(0, 3), 1'($urandom_range(0, 1)), DIR_WRITE, 0, 0, 0),
						drain);
				c = good_load($urandom_range(0, 9) < 3);
				add(c, drain);
				nt = c.quad ? c.bit_count / 4 : c.bit_count;
				if (r < 14)
					nt = $urandom_range(0, nt - 1);
				for (k = 0; k < nt; k++) begin
					if ($urandom_range(0, 19) == 0) begin
						if ($urandom_range(0, 1) == 0)
							add(mk(kind_t'($urandom_range(0, 1)), $urandom_range(0, 3),
								1'($urandom_range(0, 1)), DIR_WRITE, 0, 0, 0), 1'b0);
						else
							add(good_load(1'($urandom_range(0, 1))), 1'b0);
					end
					add(mk(KIND_TICK, 0, 0, DIR_WRITE, 0, 0, $urandom_range(0, 15)), 1'b0);
				end
				if ($urandom_range(0, 2) == 0)
					add(mk(KIND_DESELECT, $urandom_range(0, 2), 0, DIR_WRITE, 0, 0, 0), 1'b0);
			end
			drain = $urandom_range(0, 14) == 0;
		end
	endtask

	task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s expected %h actual %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : monitor
		rsp_t want;
		if (arst_n) begin
			if (cmd_valid && cmd_ready) begin
				want = bus_step(cmd);
				if (typed_now.typed)
					want = typed_now.want;
				pending_rsp.push_back(want);
			end
			if (rsp_valid && rsp_ready) begin
				if (pending_rsp.size() == 0) begin
					mismatches++;
					$display("%0t: item with none pending, expected none actual %h", $time, rsp);
				end else begin
					want = pending_rsp.pop_front();
					check_field("lines_out", DATA_W'(want.lines_out), DATA_W'(rsp.lines_out));
					check_field("selects_n", DATA_W'(want.selects_n), DATA_W'(rsp.selects_n));
					check_field("clock_pulse", DATA_W'(want.clock_pulse),
						DATA_W'(rsp.clock_pulse));
					check_field("busy_res", DATA_W'(want.busy_res), DATA_W'(rsp.busy_res));
					check_field("done_res", DATA_W'(want.done_res), DATA_W'(rsp.done_res));
					check_field("in_word", want.in_word, rsp.in_word);
					check_field("status", DATA_W'(want.status), DATA_W'(rsp.status));
				end
			end
			if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin : sender
		int    i;
		int    gap;
		int    burst_left;
		plan_t p;
		burst_left = 0;
		build_plan();
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		for (i = 0; i < plan_q.size(); i++) begin
			p = plan_q[i];
			if (p.drain) begin
				@(negedge clk) cmd_valid <= 1'b0;
				while (pending_rsp.size() != 0)
					@(negedge clk);
			end
			if (burst_left == 0) begin
				burst_left = $urandom_range(0, 4) == 0 ? 60 : $urandom_range(1, 30);
				gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
				if (gap > 0) begin
					@(negedge clk) cmd_valid <= 1'b0;
					repeat (gap - 1) @(negedge clk);
				end
			end
			@(negedge clk);
			cmd_valid <= 1'b1;
			cmd       <= p.cmd;
			typed_now <= p;
			burst_left--;
			do
				@(posedge clk);
			while (!cmd_ready);
		end
		@(negedge clk) cmd_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin : receiver
		int seg;
		int mode;
		int len;
		int phase;
		phase = 0;
		seg = 0;
		@(posedge arst_n);
		forever begin
			if (seg == 6) begin
				@(negedge clk) rsp_ready <= 1'b0;
				repeat (HOLD_OFF) @(negedge clk);
			end
			mode = $urandom_range(0, 3);
			len  = $urandom_range(10, 60);
			repeat (len) begin
				@(negedge clk);
				phase++;
				case (mode)
					0: rsp_ready <= 1'b1;
					1: rsp_ready <= 1'($urandom_range(0, 1));
					2: rsp_ready <= (phase % 3) != 0;
					default: rsp_ready <= $urandom_range(0, 3) == 0;
				endcase
			end
			seg++;
		end
	end

endmodule

### files.f
hdl/sqm_pkg.sv
hdl/sqm_in_reg.sv
hdl/sqm_core.sv
hdl/spi_quad_master_shifter.sv
verif/spi_quad_master_shifter_tb.sv
